// ===== sv/absret_sqrtcount_slope_defines.svh =====
// Assertion macros shared by the slope block.
`ifndef ABSRET_SQRTCOUNT_SLOPE_DEFINES_SVH
`define ABSRET_SQRTCOUNT_SLOPE_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASR_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASR_ASSERT(lbl, clk, rst_n, prop, msg)
`define ASR_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== sv/asr_pkg.sv =====
// ----------------------------------------------------------------------------
// asr_pkg
// Shared types and constants of the abs-return / sqrt-count slope block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package asr_pkg;
	localparam int SERIES_LEN_MAX = 4096;
	localparam int PC_W = 13;
	localparam logic [31:0] LN2_Q30 = 32'd744261118;

	// Classified bar passed from front to back.
	typedef struct packed {
		logic        pair;
		logic        last;
		logic [31:0] p1;
		logic [31:0] p0;
		logic [15:0] cnt;
	} bar_t;

	localparam int BAR_W = $bits(bar_t);
endpackage

// ===== sv/asr_front.sv =====
// ----------------------------------------------------------------------------
// asr_front
// Accepts bars, tracks the previous price and classifies whether each bar forms a pair.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module asr_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid,
	output logic             stall,
	input  logic [31:0]      price,
	input  logic             price_valid,
	input  logic [15:0]      trade_count,
	input  logic             count_valid,
	input  logic             last_in_series,
	output logic             q_wr,
	output asr_pkg::bar_t    q_data,
	input  logic             q_full
);
	logic [31:0] prev_price_q;
	logic        prev_ok_q;
	logic        ok_now;
	logic        acc;

	assign stall  = q_full;
	assign acc    = valid && !q_full;
	assign ok_now = price_valid && (price != 32'd0);
	assign q_wr   = acc;

	always_comb begin
		q_data.pair = prev_ok_q && ok_now && count_valid && (trade_count != 16'd0);
		q_data.last = last_in_series;
		q_data.p1   = price;
		q_data.p0   = prev_price_q;
		q_data.cnt  = trade_count;
	end

	// The chain restarts after the last bar of a series.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_price_q <= '0;
			prev_ok_q    <= 1'b0;
		end else if (acc) begin
			prev_price_q <= price;
			prev_ok_q    <= ok_now && !last_in_series;
		end
	end
endmodule

// ===== sv/asr_fifo.sv =====
// ----------------------------------------------------------------------------
// asr_fifo
// Two-entry queue of classified bars between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module asr_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  asr_pkg::bar_t wdata,
	output logic          full,
	input  logic          rd,
	output asr_pkg::bar_t rdata,
	output logic          empty
);
	asr_pkg::bar_t mem_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end
endmodule

// ===== sv/asr_back.sv =====
// ----------------------------------------------------------------------------
// asr_back
// Sequencer: logs, square root, sums and the end-of-series division.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "absret_sqrtcount_slope_defines.svh"
module asr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  asr_pkg::bar_t q_data,
	output logic          q_rd,
	output logic          valid,
	input  logic          stall,
	output logic [31:0]   slope,
	output logic          slope_valid
);
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_LOG  = 4'd1;
	localparam logic [3:0] ST_SQRT = 4'd2;
	localparam logic [3:0] ST_Y    = 4'd3;
	localparam logic [3:0] ST_ACC  = 4'd4;
	localparam logic [3:0] ST_M1   = 4'd5;
	localparam logic [3:0] ST_M2   = 4'd6;
	localparam logic [3:0] ST_M3   = 4'd7;
	localparam logic [3:0] ST_DIV  = 4'd8;
	localparam logic [3:0] ST_OUT  = 4'd9;
	localparam logic [3:0] ST_XY   = 4'd10;
	localparam logic [3:0] ST_RND  = 4'd11;

	logic [3:0]  st_q;
	asr_pkg::bar_t bar_q;
	// log unit: two mantissas squared together
	logic [32:0] m1_q, m0_q;
	logic [4:0]  e1_q, e0_q;
	logic [19:0] f1_q, f0_q;
	logic [4:0]  it_q;
	// sqrt unit
	logic [31:0] sa_q;
	logic [31:0] sr_q;
	logic [31:0] sbit_q;
	logic [15:0] x_q;
	logic [20:0] y_q;
	logic [24:0] d_q;
	// sums
	logic [27:0] sum_x_q;
	logic [32:0] sum_y_q;
	logic [43:0] sum_xx_q;
	logic [48:0] sum_xy_q;
	logic [asr_pkg::PC_W-1:0] pc_q;
	// division
	logic [127:0] num_q;
	logic [127:0] den_q;
	logic [128:0] rem_q;
	logic [40:0]  quo_q;
	logic [7:0]   bi_q;
	logic         neg_q;
	logic         over_q;
	logic [127:0] pa_q, pb_q;
	logic [31:0]  slope_q;
	logic         sv_q;
	logic         ovalid_q;

	logic [65:0] sq1, sq0;
	logic [4:0]  msb1, msb0;
	logic [128:0] rem_sh;
	logic [127:0] mag;
	logic [40:0] qr;
	logic [31:0] cap;

	function automatic logic [4:0] msb_idx(input logic [31:0] v);
		logic [4:0] r;
		r = '0;
		for (int i = 0; i < 32; i++) begin
			if (v[i]) r = 5'(i);
		end
		return r;
	endfunction

	assign msb1 = msb_idx(q_data.p1);
	assign msb0 = msb_idx(q_data.p0);
	assign sq1  = 66'(m1_q) * 66'(m1_q);
	assign sq0  = 66'(m0_q) * 66'(m0_q);
	assign rem_sh = {rem_q[127:0], num_q[127]};
	assign q_rd   = (st_q == ST_IDLE) && !q_empty && !(ovalid_q && stall);
	assign valid  = ovalid_q;
	assign slope  = slope_q;
	assign slope_valid = sv_q;
	assign mag = (pa_q < pb_q) ? (pb_q - pa_q) : (pa_q - pb_q);
	assign cap = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
	assign qr  = quo_q + {40'd0, (rem_q[127:0] << 1) >= den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			ovalid_q <= 1'b0;
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			sum_xx_q <= '0;
			sum_xy_q <= '0;
			pc_q     <= '0;
		end else begin
			if (ovalid_q && !stall) ovalid_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (q_rd) begin
						bar_q <= q_data;
						e1_q  <= msb1;
						e0_q  <= msb0;
						m1_q  <= {1'b0, q_data.p1 << (5'd31 - msb1)};
						m0_q  <= {1'b0, q_data.p0 << (5'd31 - msb0)};
						f1_q  <= '0;
						f0_q  <= '0;
						it_q  <= '0;
						sa_q  <= {q_data.cnt, 16'd0};
						sr_q  <= '0;
						sbit_q <= 32'h4000_0000;
						if (q_data.pair && (pc_q < asr_pkg::PC_W'(asr_pkg::SERIES_LEN_MAX)))
							st_q <= ST_LOG;
						else if (q_data.last)
							st_q <= ST_M1;
					end
				end
				ST_LOG: begin
					// One fraction bit per cycle for both logs.
					if (sq1[65:31] >= 35'h1_0000_0000) begin
						m1_q <= sq1[64:32];
						f1_q <= {f1_q[18:0], 1'b1};
					end else begin
						m1_q <= sq1[63:31];
						f1_q <= {f1_q[18:0], 1'b0};
					end
					if (sq0[65:31] >= 35'h1_0000_0000) begin
						m0_q <= sq0[64:32];
						f0_q <= {f0_q[18:0], 1'b1};
					end else begin
						m0_q <= sq0[63:31];
						f0_q <= {f0_q[18:0], 1'b0};
					end
					it_q <= it_q + 5'd1;
					if (it_q == 5'd19) st_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (sbit_q != 32'd0) begin
						if ({1'b0, sa_q} >= {1'b0, sr_q} + {1'b0, sbit_q}) begin
							sa_q <= sa_q - sr_q - sbit_q;
							sr_q <= (sr_q >> 1) + sbit_q;
						end else begin
							sr_q <= sr_q >> 1;
						end
						sbit_q <= sbit_q >> 2;
					end else begin
						st_q <= ST_Y;
					end
				end
				ST_Y: begin
					if (sa_q > sr_q)
						x_q <= (sr_q >= 32'hFFFF) ? 16'hFFFF : 16'(sr_q + 32'd1);
					else
						x_q <= (sr_q > 32'hFFFF) ? 16'hFFFF : sr_q[15:0];
					if ({e1_q, f1_q} >= {e0_q, f0_q})
						d_q <= {e1_q, f1_q} - {e0_q, f0_q};
					else
						d_q <= {e0_q, f0_q} - {e1_q, f1_q};
					st_q <= ST_ACC;
				end
				ST_ACC: begin
					y_q  <= 21'((57'(d_q) * 57'(asr_pkg::LN2_Q30) + (57'd1 << 33)) >> 34);
					st_q <= ST_XY;
				end
				ST_XY: begin
					sum_x_q  <= sum_x_q + 28'(x_q);
					sum_y_q  <= sum_y_q + 33'(y_q);
					sum_xx_q <= sum_xx_q + 44'(32'(x_q) * 32'(x_q));
					sum_xy_q <= sum_xy_q + 49'(37'(x_q) * 37'(y_q));
					pc_q     <= pc_q + asr_pkg::PC_W'(1);
					st_q     <= bar_q.last ? ST_M1 : ST_IDLE;
				end
				ST_M1: begin
					pa_q <= 128'(pc_q) * 128'(sum_xx_q);
					pb_q <= 128'(sum_x_q) * 128'(sum_x_q);
					st_q <= ST_M2;
				end
				ST_M2: begin
					den_q <= pa_q - pb_q;
					pa_q  <= 128'(pc_q) * 128'(sum_xy_q);
					pb_q  <= 128'(sum_x_q) * 128'(sum_y_q);
					st_q  <= ST_M3;
				end
				ST_M3: begin
					neg_q  <= pa_q < pb_q;
					num_q  <= mag << 8;
					rem_q  <= '0;
					quo_q  <= '0;
					over_q <= 1'b0;
					bi_q   <= 8'd127;
					if (pc_q < 13'd2 || den_q == 128'd0) begin
						slope_q <= '0;
						sv_q    <= 1'b0;
						st_q    <= ST_OUT;
					end else begin
						st_q    <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (rem_sh >= {1'b0, den_q}) begin
						rem_q <= rem_sh - {1'b0, den_q};
						if (bi_q >= 8'd40) over_q <= 1'b1;
						else quo_q[bi_q[5:0]] <= 1'b1;
					end else begin
						rem_q <= rem_sh;
					end
					num_q <= num_q << 1;
					bi_q  <= bi_q - 8'd1;
					if (bi_q == 8'd0) st_q <= ST_RND;
				end
				ST_OUT: begin
					if (!ovalid_q) begin
						ovalid_q <= 1'b1;
						sum_x_q  <= '0;
						sum_y_q  <= '0;
						sum_xx_q <= '0;
						sum_xy_q <= '0;
						pc_q     <= '0;
						st_q     <= ST_IDLE;
					end
				end
				ST_RND: begin
					if (over_q || qr > 41'(cap)) begin
						slope_q <= neg_q ? 32'h8000_0000 : cap;
					end else begin
						slope_q <= neg_q ? (32'd0 - qr[31:0]) : qr[31:0];
					end
					sv_q <= 1'b1;
					st_q <= ST_OUT;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	`ASR_NEVER(a_no_read_busy, clk, arst_n, q_rd && st_q != ST_IDLE, "read while busy")
	`ASR_ASSERT(a_inv_zero, clk, arst_n, (valid && !slope_valid) |-> slope == 32'd0, "bad slope")
	`ASR_ASSERT(a_out_hold, clk, arst_n, (valid && stall) |=> valid, "result dropped")
endmodule

// ===== sv/absret_sqrtcount_slope.sv =====
// ----------------------------------------------------------------------------
// absret_sqrtcount_slope
// Least-squares slope of absolute log return on square-root trade count.
// ----------------------------------------------------------------------------
// A bar that forms a pair is taken from the queue and then passes the two
// log-squaring units (one per price, working side by side), the square-root unit
// and the steps for y and the sums; other bars are only taken from the queue.
// The last bar of a series then passes the product steps, the one-bit-a-cycle
// 128-bit divider, rounding and the step that loads the result. A two-item queue
// lets the front accept bars while the back end works.
`timescale 1ns / 1ps
module absret_sqrtcount_slope (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] price,
	input  logic        price_valid,
	input  logic [15:0] trade_count,
	input  logic        count_valid,
	input  logic        last_in_series,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] slope,
	output logic        slope_valid
);
	logic          q_wr, q_full, q_rd, q_empty;
	asr_pkg::bar_t q_wdata, q_rdata;

	asr_front u_front (
		.clk, .arst_n, .valid(in_valid), .stall(in_stall), .price, .price_valid,
		.trade_count, .count_valid, .last_in_series,
		.q_wr, .q_data(q_wdata), .q_full
	);
	asr_fifo u_fifo (
		.clk, .arst_n, .wr(q_wr), .wdata(q_wdata), .full(q_full),
		.rd(q_rd), .rdata(q_rdata), .empty(q_empty)
	);
	asr_back u_back (
		.clk, .arst_n, .q_empty, .q_data(q_rdata), .q_rd,
		.valid(out_valid), .stall(out_stall), .slope, .slope_valid
	);
endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the abs-return / sqrt-count slope block.
// ----------------------------------------------------------------------------
// A short table of directed bars is sent first, then random series.
// Every series end is predicted in integer arithmetic and compared with the
// slope that the block emits. The sender and the receiver idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
	localparam int  N_RANDOM  = 1850;
	localparam int  DRAIN_CYC = 400;
	localparam longint CYC_LIMIT = 3000000;
	localparam logic [63:0] POS_CAP = 64'h7FFF_FFFF;
	localparam logic [63:0] NEG_CAP = 64'h8000_0000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] price;
	logic        price_valid;
	logic [15:0] trade_count;
	logic        count_valid;
	logic        last_in_series;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] slope;
	logic        slope_valid;

	typedef struct packed {
		logic [31:0] slope;
		logic        valid;
	} slope_res_t;

	typedef struct {
		logic [31:0] price;
		logic        pv;
		logic [15:0] cnt;
		logic        cv;
		logic        last;
		logic        typed;
		slope_res_t  res;
	} bar_row_t;

	// Running series state of the predictor.
	logic [31:0]  prev_px;
	logic         prev_px_ok;
	logic [63:0]  acc_x, acc_y, acc_xx, acc_xy;
	logic [31:0]  acc_n;

	slope_res_t   slope_q[$];
	int           errors;
	int           mismatches;
	longint       cycles;
	int           send_idle_pct;
	int           recv_stall_pct;

	absret_sqrtcount_slope u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.price(price), .price_valid(price_valid),
		.trade_count(trade_count), .count_valid(count_valid),
		.last_in_series(last_in_series),
		.out_valid(out_valid), .out_stall(out_stall),
		.slope(slope), .slope_valid(slope_valid)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [63:0] log2_fix(input logic [31:0] v);
		int e;
		logic [63:0] m, f;
		if (v == 0)
			return 0;
		e = 31;
		while (v[e] == 1'b0)
			e--;
		m = 64'(v) << (31 - e);
		f = 0;
		for (int i = 0; i < 20; i++) begin
			m = (m * m) >> 31;
			f = f << 1;
			if (m >= 64'h1_0000_0000) begin
				f[0] = 1'b1;
				m = m >> 1;
			end
		end
		return (64'(e) << 20) | f;
	endfunction

	function automatic logic [63:0] sqrt_q8(input logic [15:0] n);
		logic [63:0] a, r, b;
		a = 64'(n) << 16;
		r = 0;
		b = 64'h1_0000_0000;
		while (b > a)
			b = b >> 2;
		while (b != 0) begin
			if (a >= r + b) begin
				a = a - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		if (a > r)
			r++;
		return (r > 64'hFFFF) ? 64'hFFFF : r;
	endfunction

	function automatic void clear_series();
		prev_px = 0;
		prev_px_ok = 1'b0;
		acc_x = 0;
		acc_y = 0;
		acc_xx = 0;
		acc_xy = 0;
		acc_n = 0;
	endfunction

	// Advances the series state by one bar; returns 1 with the slope on a last bar.
	function automatic bit slope_step(input logic [31:0] px, input logic pv,
			input logic [15:0] n, input logic cv, input logic last,
			output slope_res_t res);
		logic ok_now;
		logic [63:0] l1, l0, d, y, x;
		logic [127:0] den, a, b, mag, q, r;
		logic neg;
		ok_now = pv && px != 0;
		if (prev_px_ok && ok_now && cv && n > 0 && acc_n < asr_pkg::SERIES_LEN_MAX) begin
			l1 = log2_fix(px);
			l0 = log2_fix(prev_px);
			d = (l1 >= l0) ? l1 - l0 : l0 - l1;
			y = (d * 64'(asr_pkg::LN2_Q30) + (64'd1 << 33)) >> 34;
			x = sqrt_q8(n);
			acc_x += x;
			acc_y += y;
			acc_xx += x * x;
			acc_xy += x * y;
			acc_n++;
		end
		prev_px = px;
		prev_px_ok = ok_now;
		res = '0;
		if (!last)
			return 0;
		if (acc_n >= 2) begin
			den = 128'(acc_n) * 128'(acc_xx) - 128'(acc_x) * 128'(acc_x);
			if (den != 0) begin
				a = 128'(acc_n) * 128'(acc_xy);
				b = 128'(acc_x) * 128'(acc_y);
				neg = a < b;
				mag = (neg ? b - a : a - b) << 8;
				q = mag / den;
				r = mag % den;
				if ((r << 1) >= den)
					q++;
				if (neg) begin
					if (q > 128'(NEG_CAP))
						q = 128'(NEG_CAP);
					res.slope = 32'(-q[31:0]);
				end else begin
					if (q > 128'(POS_CAP))
						q = 128'(POS_CAP);
					res.slope = q[31:0];
				end
				res.valid = 1'b1;
			end
		end
		clear_series();
		return 1;
	endfunction

	task automatic send_bar(input bar_row_t row);
		slope_res_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		price <= row.price;
		price_valid <= row.pv;
		trade_count <= row.cnt;
		count_valid <= row.cv;
		last_in_series <= row.last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (slope_step(row.price, row.pv, row.cnt, row.cv, row.last, res)) begin
			if (row.typed && res != row.res) begin
				errors++;
				$display("table row disagrees with predictor: %h vs %h", row.res, res);
			end
			slope_q.push_back(res);
		end
		@(negedge clk);
	endtask

	function automatic bar_row_t mk(input logic [31:0] p, input logic pv,
			input logic [15:0] n, input logic cv, input logic last);
		bar_row_t row;
		row.price = p;
		row.pv = pv;
		row.cnt = n;
		row.cv = cv;
		row.last = last;
		row.typed = 1'b0;
		row.res = '0;
		return row;
	endfunction

	function automatic bar_row_t mk_typed(input bar_row_t row, input slope_res_t res);
		row.typed = 1'b1;
		row.res = res;
		return row;
	endfunction

	function automatic logic [31:0] rand_price();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'h0001_0000 + $urandom_range(4096);
			2: return 32'hFFFF_FFFF - $urandom_range(3);
			3: return $urandom_range(1, 3);
			default: return 32'h0064_0000 + $urandom_range(65535) - 32768;
		endcase
	endfunction

	task automatic send_random_series();
		int len;
		bit clean;
		logic [15:0] n;
		bar_row_t row;
		len = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(2, 12);
		clean = $urandom_range(3) != 0;
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(3))
				0: n = 16'($urandom);
				1: n = 16'($urandom_range(1, 4));
				default: n = 16'($urandom_range(1, 400));
			endcase
			row = mk(rand_price(), 1'b1, n, 1'b1, i == len - 1);
			if (!clean) begin
				if ($urandom_range(4) == 0) row.pv = 1'b0;
				if ($urandom_range(4) == 0) row.cv = 1'b0;
				if ($urandom_range(5) == 0) row.price = 32'd0;
				if ($urandom_range(5) == 0) row.cnt = 16'd0;
			end
			send_bar(row);
		end
	endtask

	// Receiver: stalls at random and checks each slope against the oldest one expected.
	always @(posedge clk) begin
		slope_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (slope_q.size() == 0) begin
				errors++;
				if (mismatches < 10)
					$display("unexpected slope %h valid %b", slope, slope_valid);
				mismatches++;
			end else begin
				want = slope_q.pop_front();
				if (slope !== want.slope || slope_valid !== want.valid) begin
					errors++;
					if (mismatches < 10)
						$display("slope mismatch: expected %h/%b, got %h/%b",
							want.slope, want.valid, slope, slope_valid);
					mismatches++;
				end
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYC_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		bar_row_t tbl[$];
		slope_res_t none;
		int sent;
		none = '0;
		errors = 0;
		mismatches = 0;
		cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		price = 0;
		price_valid = 1'b0;
		trade_count = 0;
		count_valid = 1'b0;
		last_in_series = 1'b0;
		out_stall = 1'b0;
		clear_series();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// One-bar series gives an invalid slope.
		tbl.push_back(mk_typed(mk(32'h0001_0000, 1'b1, 16'd4, 1'b1, 1'b1), none));
		// Zero price breaks the chain: one pair only.
		tbl.push_back(mk(32'h0001_0000, 1'b1, 16'd1, 1'b1, 1'b0));
		tbl.push_back(mk(32'h0000_0000, 1'b1, 16'd9, 1'b1, 1'b0));
		tbl.push_back(mk(32'h0002_0000, 1'b1, 16'd9, 1'b1, 1'b0));
		tbl.push_back(mk_typed(mk(32'h0004_0000, 1'b1, 16'd4, 1'b1, 1'b1), none));
		// Equal counts give zero x variance.
		tbl.push_back(mk(32'h0001_0000, 1'b1, 16'd7, 1'b1, 1'b0));
		tbl.push_back(mk(32'h0002_0000, 1'b1, 16'd7, 1'b1, 1'b0));
		tbl.push_back(mk_typed(mk(32'h0001_0000, 1'b1, 16'd7, 1'b1, 1'b1), none));
		// Extremes of price and count; missing flags.
		tbl.push_back(mk(32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1'b1, 1'b0));
		tbl.push_back(mk(32'h0000_0001, 1'b1, 16'hFFFF, 1'b1, 1'b0));
		tbl.push_back(mk(32'hFFFF_FFFF, 1'b1, 16'd1, 1'b1, 1'b0));
		tbl.push_back(mk(32'h0000_0001, 1'b1, 16'd0, 1'b1, 1'b0));
		tbl.push_back(mk(32'hFFFF_FFFF, 1'b0, 16'd3, 1'b1, 1'b0));
		tbl.push_back(mk(32'h0001_0000, 1'b1, 16'd3, 1'b0, 1'b0));
		tbl.push_back(mk(32'h0000_0001, 1'b1, 16'd1, 1'b1, 1'b0));
		tbl.push_back(mk(32'hFFFF_FFFF, 1'b1, 16'd2, 1'b1, 1'b1));
		// Saturating positive and negative slopes.
		tbl.push_back(mk(32'h0000_0001, 1'b1, 16'd1, 1'b1, 1'b0));
		tbl.push_back(mk(32'h0000_0001, 1'b1, 16'd1, 1'b1, 1'b0));
		tbl.push_back(mk(32'hFFFF_FFFF, 1'b1, 16'd2, 1'b1, 1'b1));
		tbl.push_back(mk(32'h0000_0001, 1'b1, 16'd1, 1'b1, 1'b0));
		tbl.push_back(mk(32'hFFFF_FFFF, 1'b1, 16'd1, 1'b1, 1'b0));
		tbl.push_back(mk(32'hFFFF_FFFF, 1'b1, 16'd2, 1'b1, 1'b1));
		@(negedge clk);
		foreach (tbl[i])
			send_bar(tbl[i]);

		sent = 0;
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				1: begin send_idle_pct = 88; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 88; end
				3: begin send_idle_pct = 19; recv_stall_pct = 19; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			while (sent < (ph + 1) * N_RANDOM / 5) begin
				send_random_series();
				sent += 7;
			end
		end
		in_valid <= 1'b0;
		recv_stall_pct = 0;
		while (slope_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+sv
sv/asr_pkg.sv
sv/asr_front.sv
sv/asr_fifo.sv
sv/asr_back.sv
sv/absret_sqrtcount_slope.sv
test/tb_top.sv
